/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the point arithmetic block.
// Needs signals clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ECPA_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define ECPA_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("assertion failed");
`else
`define ECPA_ASSERT(label, prop)
`define ECPA_NEVER(label, expr)
`endif
`endif

/* rtl/ecpa_pkg.sv */
// Shared types, constants and the microcode table of the point arithmetic block.
// Used by ecpa_dp, ecpa_ctrl and ec_point_add_scalar_multiply.
package ecpa_pkg;

	localparam int W = 16;
	localparam int MaxMultiple = 255;
	localparam int NW = 8;
	localparam int RegAw = 4;
	localparam int NRegs = 2 ** RegAw;
	localparam int PcW = 6;
	localparam int SDataW = ((4 * W + NW + 7) / 8) * 8;
	localparam int MDataW = ((2 * W + 7) / 8) * 8;

	typedef logic [W-1:0] word_t;
	typedef logic [NW-1:0] mult_t;
	typedef logic [RegAw-1:0] raddr_t;
	typedef logic [PcW-1:0] pc_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_TEST, OP_MOVE, OP_ADD, OP_SUB, OP_MULMOD,
		OP_DIVREM, OP_REDUCE, OP_LOADM, OP_LOAD0, OP_LOAD1
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER, C_ALWAYS, C_EQ, C_NEQ, C_ZERO, C_ONE, C_ADDCMD, C_INF, C_CNTZERO
	} cond_t;

	typedef enum logic [2:0] {
		K_NONE, K_SETINF, K_CLRINF, K_DECN, K_FINISH
	} kind_t;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CFG_MODULUS = 1'b0;
	localparam logic CFG_CURVE_A = 1'b1;

	// Register file map.
	localparam raddr_t R_X1 = 4'd0;
	localparam raddr_t R_Y1 = 4'd1;
	localparam raddr_t R_X2 = 4'd2;
	localparam raddr_t R_Y2 = 4'd3;
	localparam raddr_t R_A = 4'd4;
	localparam raddr_t R_NUM = 4'd5;
	localparam raddr_t R_DEN = 4'd6;
	localparam raddr_t R_LAM = 4'd7;
	localparam raddr_t R_T = 4'd8;
	localparam raddr_t R_R1 = 4'd9;
	localparam raddr_t R_R2 = 4'd10;
	localparam raddr_t R_T1 = 4'd11;
	localparam raddr_t R_T2 = 4'd12;
	localparam raddr_t R_Q = 4'd13;

	// Sources of the reduce operation.
	localparam raddr_t SRC_FX = 4'd0;
	localparam raddr_t SRC_FY = 4'd1;
	localparam raddr_t SRC_SX = 4'd2;
	localparam raddr_t SRC_SY = 4'd3;
	localparam raddr_t SRC_CA = 4'd4;

	// Microcode entry points.
	localparam pc_t PC_ADD = 6'd7;
	localparam pc_t PC_TAN = 6'd11;
	localparam pc_t PC_INV = 6'd18;
	localparam pc_t PC_LOOP = 6'd22;
	localparam pc_t PC_EXIT = 6'd30;
	localparam pc_t PC_LAM = 6'd32;
	localparam pc_t PC_VERT = 6'd40;
	localparam pc_t PC_INFP = 6'd41;
	localparam pc_t PC_NEXT = 6'd43;
	localparam pc_t PC_DONE = 6'd46;
	localparam pc_t PC_SRCQ = 6'd5;

	typedef struct packed {
		logic start;
		logic load_in;
		op_t op;
		raddr_t a;
		raddr_t b;
		raddr_t d;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic eq;
		logic zero;
		logic one;
	} dp_stat_t;

	typedef struct packed {
		op_t op;
		raddr_t a;
		raddr_t b;
		raddr_t d;
		cond_t cond;
		kind_t kind;
		pc_t tgt;
	} uinst_t;

	function automatic uinst_t mk(input op_t op, input raddr_t a, input raddr_t b,
		input raddr_t d, input cond_t cond, input kind_t kind, input pc_t tgt);
		uinst_t u;
		u.op = op;
		u.a = a;
		u.b = b;
		u.d = d;
		u.cond = cond;
		u.kind = kind;
		u.tgt = tgt;
		return u;
	endfunction

	// Point addition and the scalar multiply loop, with the slope inverse by the extended Euclidean algorithm.
	// The running sum lives in X1/Y1 and the second operand in X2/Y2.
	function automatic uinst_t ucode(input pc_t pc);
		uinst_t u;
		unique case (pc)
			6'd0: u = mk(OP_REDUCE, SRC_FX, R_X1, R_X1, C_NEVER, K_NONE, PC_ADD);
			6'd1: u = mk(OP_REDUCE, SRC_FY, R_X1, R_Y1, C_NEVER, K_NONE, PC_ADD);
			6'd2: u = mk(OP_REDUCE, SRC_CA, R_X1, R_A, C_ADDCMD, K_NONE, PC_SRCQ);
			6'd3: u = mk(OP_REDUCE, SRC_FX, R_X1, R_X2, C_NEVER, K_NONE, PC_ADD);
			6'd4: u = mk(OP_REDUCE, SRC_FY, R_X1, R_Y2, C_ALWAYS, K_NONE, PC_NEXT);
			6'd5: u = mk(OP_REDUCE, SRC_SX, R_X1, R_X2, C_NEVER, K_NONE, PC_ADD);
			6'd6: u = mk(OP_REDUCE, SRC_SY, R_X1, R_Y2, C_NEVER, K_NONE, PC_ADD);
			6'd7: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_INF, K_NONE, PC_INFP);
			6'd8: u = mk(OP_TEST, R_X1, R_X2, R_X1, C_EQ, K_NONE, PC_TAN);
			6'd9: u = mk(OP_SUB, R_Y2, R_Y1, R_NUM, C_NEVER, K_NONE, PC_ADD);
			6'd10: u = mk(OP_SUB, R_X2, R_X1, R_DEN, C_ALWAYS, K_NONE, PC_INV);
			6'd11: u = mk(OP_TEST, R_Y1, R_Y2, R_X1, C_NEQ, K_NONE, PC_VERT);
			6'd12: u = mk(OP_ADD, R_Y1, R_Y1, R_DEN, C_NEVER, K_NONE, PC_ADD);
			6'd13: u = mk(OP_TEST, R_DEN, R_DEN, R_X1, C_ZERO, K_NONE, PC_VERT);
			6'd14: u = mk(OP_MULMOD, R_X1, R_X1, R_T, C_NEVER, K_NONE, PC_ADD);
			6'd15: u = mk(OP_ADD, R_T, R_T, R_NUM, C_NEVER, K_NONE, PC_ADD);
			6'd16: u = mk(OP_ADD, R_NUM, R_T, R_NUM, C_NEVER, K_NONE, PC_ADD);
			6'd17: u = mk(OP_ADD, R_NUM, R_A, R_NUM, C_NEVER, K_NONE, PC_ADD);
			6'd18: u = mk(OP_LOADM, R_X1, R_X1, R_R1, C_NEVER, K_NONE, PC_ADD);
			6'd19: u = mk(OP_MOVE, R_DEN, R_X1, R_R2, C_NEVER, K_NONE, PC_ADD);
			6'd20: u = mk(OP_LOAD0, R_X1, R_X1, R_T1, C_NEVER, K_NONE, PC_ADD);
			6'd21: u = mk(OP_LOAD1, R_X1, R_X1, R_T2, C_NEVER, K_NONE, PC_ADD);
			6'd22: u = mk(OP_TEST, R_R2, R_R2, R_X1, C_ZERO, K_NONE, PC_EXIT);
			6'd23: u = mk(OP_DIVREM, R_R1, R_R2, R_T, C_NEVER, K_NONE, PC_ADD);
			6'd24: u = mk(OP_MOVE, R_R2, R_X1, R_R1, C_NEVER, K_NONE, PC_ADD);
			6'd25: u = mk(OP_MOVE, R_T, R_X1, R_R2, C_NEVER, K_NONE, PC_ADD);
			6'd26: u = mk(OP_MULMOD, R_Q, R_T2, R_T, C_NEVER, K_NONE, PC_ADD);
			6'd27: u = mk(OP_SUB, R_T1, R_T, R_T, C_NEVER, K_NONE, PC_ADD);
			6'd28: u = mk(OP_MOVE, R_T2, R_X1, R_T1, C_NEVER, K_NONE, PC_ADD);
			6'd29: u = mk(OP_MOVE, R_T, R_X1, R_T2, C_ALWAYS, K_NONE, PC_LOOP);
			6'd30: u = mk(OP_TEST, R_R1, R_R1, R_X1, C_ONE, K_NONE, PC_LAM);
			6'd31: u = mk(OP_LOAD0, R_X1, R_X1, R_T1, C_NEVER, K_NONE, PC_ADD);
			6'd32: u = mk(OP_MULMOD, R_NUM, R_T1, R_LAM, C_NEVER, K_NONE, PC_ADD);
			6'd33: u = mk(OP_MULMOD, R_LAM, R_LAM, R_T, C_NEVER, K_NONE, PC_ADD);
			6'd34: u = mk(OP_SUB, R_T, R_X1, R_T, C_NEVER, K_NONE, PC_ADD);
			6'd35: u = mk(OP_SUB, R_T, R_X2, R_T, C_NEVER, K_NONE, PC_ADD);
			6'd36: u = mk(OP_SUB, R_X1, R_T, R_NUM, C_NEVER, K_NONE, PC_ADD);
			6'd37: u = mk(OP_MULMOD, R_LAM, R_NUM, R_NUM, C_NEVER, K_NONE, PC_ADD);
			6'd38: u = mk(OP_SUB, R_NUM, R_Y1, R_Y1, C_NEVER, K_NONE, PC_ADD);
			6'd39: u = mk(OP_MOVE, R_T, R_X1, R_X1, C_ALWAYS, K_NONE, PC_NEXT);
			6'd40: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_ALWAYS, K_SETINF, PC_NEXT);
			6'd41: u = mk(OP_MOVE, R_X2, R_X1, R_X1, C_NEVER, K_NONE, PC_ADD);
			6'd42: u = mk(OP_MOVE, R_Y2, R_X1, R_Y1, C_NEVER, K_CLRINF, PC_ADD);
			6'd43: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_ADDCMD, K_NONE, PC_DONE);
			6'd44: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_CNTZERO, K_NONE, PC_DONE);
			6'd45: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_ALWAYS, K_DECN, PC_ADD);
			6'd46: u = mk(OP_TEST, R_X1, R_Y1, R_X1, C_NEVER, K_FINISH, PC_ADD);
			default: u = mk(OP_NOP, R_X1, R_X1, R_X1, C_ALWAYS, K_NONE, PC_DONE);
		endcase
		return u;
	endfunction

endpackage

/* rtl/ecpa_dp.sv */
// Datapath: register file, modular add/subtract and a shared restoring divider for input
// reductions, products mod p and Euclid quotients. Depends on ecpa_pkg.
module ecpa_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ecpa_pkg::dp_cmd_t cmd,
	output ecpa_pkg::dp_stat_t stat,
	input  ecpa_pkg::word_t   modulus,
	input  ecpa_pkg::word_t   curve_a,
	input  ecpa_pkg::word_t   first_x,
	input  ecpa_pkg::word_t   first_y,
	input  ecpa_pkg::word_t   second_x,
	input  ecpa_pkg::word_t   second_y,
	output ecpa_pkg::word_t   rd_a,
	output ecpa_pkg::word_t   rd_b
);

	localparam int DvdW = 2 * ecpa_pkg::W;
	localparam int CntW = $clog2(DvdW + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_EX, ST_DIV, ST_WQ, ST_DONE} st_t;

	st_t                 st_q;
	ecpa_pkg::word_t     rf_q [ecpa_pkg::NRegs];
	ecpa_pkg::word_t     fx_q, fy_q, sx_q, sy_q;
	ecpa_pkg::word_t     rda_q, rdb_q, src_q, div_q;
	ecpa_pkg::op_t       op_q;
	ecpa_pkg::raddr_t    d_q;
	logic [DvdW-1:0]     dvd_q;
	logic [ecpa_pkg::W:0] rem_q;
	logic [CntW-1:0]     cnt_q;
	logic                eq_q, zero_q, one_q;

	logic [ecpa_pkg::W:0] rem_sh, rem_nxt, sum, diff;
	logic                 ge, last;
	logic                 we;
	ecpa_pkg::raddr_t     wa;
	ecpa_pkg::word_t      wd, field;

	// One restoring division step per cycle.
	assign rem_sh = {rem_q[ecpa_pkg::W-1:0], dvd_q[DvdW-1]};
	assign ge = rem_sh >= {1'b0, div_q};
	assign rem_nxt = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
	assign last = cnt_q == CntW'(1);

	assign sum = {1'b0, rda_q} + {1'b0, rdb_q};
	assign diff = {1'b0, rda_q} + {1'b0, modulus} - {1'b0, rdb_q};

	always_comb begin
		case (cmd.a)
			ecpa_pkg::SRC_FX: field = fx_q;
			ecpa_pkg::SRC_FY: field = fy_q;
			ecpa_pkg::SRC_SX: field = sx_q;
			ecpa_pkg::SRC_SY: field = sy_q;
			default:          field = curve_a;
		endcase
	end

	always_comb begin
		we = 1'b0;
		wa = d_q;
		wd = rda_q;
		case (st_q)
			ST_EX: begin
				case (op_q)
					ecpa_pkg::OP_MOVE: we = 1'b1;
					ecpa_pkg::OP_ADD: begin
						we = 1'b1;
						wd = (sum >= {1'b0, modulus}) ? ecpa_pkg::W'(sum - {1'b0, modulus})
							: ecpa_pkg::W'(sum);
					end
					ecpa_pkg::OP_SUB: begin
						we = 1'b1;
						wd = (rda_q >= rdb_q) ? (rda_q - rdb_q) : ecpa_pkg::W'(diff);
					end
					ecpa_pkg::OP_LOADM: begin
						we = 1'b1;
						wd = modulus;
					end
					ecpa_pkg::OP_LOAD0: begin
						we = 1'b1;
						wd = '0;
					end
					ecpa_pkg::OP_LOAD1: begin
						we = 1'b1;
						wd = ecpa_pkg::W'(1);
					end
					default: ;
				endcase
			end
			ST_DIV: begin
				we = last;
				wd = rem_nxt[ecpa_pkg::W-1:0];
			end
			ST_WQ: begin
				we = 1'b1;
				wa = ecpa_pkg::R_Q;
				wd = dvd_q[ecpa_pkg::W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: if (cmd.start) st_q <= ST_RD;
				ST_RD:   st_q <= ST_EX;
				ST_EX: begin
					if (op_q == ecpa_pkg::OP_MULMOD || op_q == ecpa_pkg::OP_DIVREM
						|| op_q == ecpa_pkg::OP_REDUCE) begin
						st_q <= ST_DIV;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_DIV: if (last) st_q <= (op_q == ecpa_pkg::OP_DIVREM) ? ST_WQ : ST_DONE;
				ST_WQ:   st_q <= ST_DONE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) rf_q[wa] <= wd;
		if (cmd.load_in) begin
			fx_q <= first_x;
			fy_q <= first_y;
			sx_q <= second_x;
			sy_q <= second_y;
		end
		if (st_q == ST_IDLE && cmd.start) begin
			op_q <= cmd.op;
			d_q <= cmd.d;
			src_q <= field;
		end
		if (st_q == ST_RD) begin
			rda_q <= rf_q[cmd.a];
			rdb_q <= rf_q[cmd.b];
		end
		if (st_q == ST_EX) begin
			rem_q <= '0;
			eq_q <= rda_q == rdb_q;
			zero_q <= rda_q == '0;
			one_q <= rda_q == ecpa_pkg::W'(1);
			case (op_q)
				ecpa_pkg::OP_MULMOD: begin
					dvd_q <= rda_q * rdb_q;
					div_q <= modulus;
					cnt_q <= CntW'(DvdW);
				end
				ecpa_pkg::OP_DIVREM: begin
					dvd_q <= {rda_q, ecpa_pkg::W'(0)};
					div_q <= rdb_q;
					cnt_q <= CntW'(ecpa_pkg::W);
				end
				default: begin
					dvd_q <= {src_q, ecpa_pkg::W'(0)};
					div_q <= modulus;
					cnt_q <= CntW'(ecpa_pkg::W);
				end
			endcase
		end
		if (st_q == ST_DIV) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[DvdW-2:0], ge};
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	assign stat.busy = st_q != ST_IDLE;
	assign stat.done = st_q == ST_DONE;
	assign stat.eq = eq_q;
	assign stat.zero = zero_q;
	assign stat.one = one_q;
	assign rd_a = rda_q;
	assign rd_b = rdb_q;

endmodule

/* rtl/ecpa_ctrl.sv */
// Microcoded controller: sequences datapath operations, counts additions of a
// scalar multiply and holds the output register. Depends on ecpa_pkg.
`include "assert_macros.svh"
module ecpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_cmd,
	input  ecpa_pkg::mult_t    in_multiple,
	input  logic               m_small,
	output ecpa_pkg::dp_cmd_t  dp_cmd,
	input  ecpa_pkg::dp_stat_t dp_stat,
	input  ecpa_pkg::word_t    rd_a,
	input  ecpa_pkg::word_t    rd_b,
	output logic               out_valid,
	input  logic               out_ready,
	output ecpa_pkg::word_t    out_x,
	output ecpa_pkg::word_t    out_y,
	output logic               out_inf
);

	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_t;

	state_t            st_q;
	ecpa_pkg::pc_t     pc_q;
	ecpa_pkg::mult_t   cnt_q;
	logic              cmd_q, inf_q, start_q;
	ecpa_pkg::op_t     op_q;
	ecpa_pkg::raddr_t  a_q, b_q, d_q;
	ecpa_pkg::word_t   res_x_q, res_y_q, out_x_q, out_y_q;
	logic              res_inf_q, out_valid_q, out_inf_q;

	ecpa_pkg::uinst_t  u;
	ecpa_pkg::mult_t   n;
	logic              accept, step, taken;

	assign u = ecpa_pkg::ucode(pc_q);
	assign accept = in_valid && in_ready;
	assign n = (int'(in_multiple) > ecpa_pkg::MaxMultiple)
		? ecpa_pkg::NW'(ecpa_pkg::MaxMultiple) : in_multiple;
	assign step = (st_q == S_ISSUE && u.op == ecpa_pkg::OP_NOP)
		|| (st_q == S_WAIT && dp_stat.done);

	always_comb begin
		unique case (u.cond)
			ecpa_pkg::C_ALWAYS:  taken = 1'b1;
			ecpa_pkg::C_EQ:      taken = dp_stat.eq;
			ecpa_pkg::C_NEQ:     taken = !dp_stat.eq;
			ecpa_pkg::C_ZERO:    taken = dp_stat.zero;
			ecpa_pkg::C_ONE:     taken = dp_stat.one;
			ecpa_pkg::C_ADDCMD:  taken = cmd_q == ecpa_pkg::CMD_ADD;
			ecpa_pkg::C_INF:     taken = inf_q;
			ecpa_pkg::C_CNTZERO: taken = cnt_q == '0;
			default:             taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pc_q <= '0;
			cnt_q <= '0;
			cmd_q <= 1'b0;
			inf_q <= 1'b0;
			start_q <= 1'b0;
			op_q <= ecpa_pkg::OP_NOP;
			a_q <= '0;
			b_q <= '0;
			d_q <= '0;
			res_x_q <= '0;
			res_y_q <= '0;
			res_inf_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_x_q <= '0;
			out_y_q <= '0;
			out_inf_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= in_cmd;
						pc_q <= '0;
						inf_q <= 1'b0;
						cnt_q <= n - ecpa_pkg::NW'(1);
						if (m_small || (in_cmd != ecpa_pkg::CMD_ADD && n == '0)) begin
							res_x_q <= '0;
							res_y_q <= '0;
							res_inf_q <= 1'b1;
							st_q <= S_OUT;
						end else begin
							st_q <= S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					if (u.op != ecpa_pkg::OP_NOP) begin
						start_q <= 1'b1;
						op_q <= u.op;
						a_q <= u.a;
						b_q <= u.b;
						d_q <= u.d;
						st_q <= S_WAIT;
					end
				end
				S_WAIT: ;
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_x_q <= res_x_q;
						out_y_q <= res_y_q;
						out_inf_q <= res_inf_q;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
			// Completion of a microinstruction: side effect, then branch.
			if (step) begin
				case (u.kind)
					ecpa_pkg::K_SETINF: inf_q <= 1'b1;
					ecpa_pkg::K_CLRINF: inf_q <= 1'b0;
					ecpa_pkg::K_DECN:   cnt_q <= cnt_q - ecpa_pkg::NW'(1);
					default: ;
				endcase
				if (u.kind == ecpa_pkg::K_FINISH) begin
					res_x_q <= inf_q ? '0 : rd_a;
					res_y_q <= inf_q ? '0 : rd_b;
					res_inf_q <= inf_q;
					st_q <= S_OUT;
				end else begin
					pc_q <= taken ? u.tgt : pc_q + ecpa_pkg::PcW'(1);
					st_q <= S_ISSUE;
				end
			end
		end
	end

	assign in_ready = st_q == S_IDLE;
	assign dp_cmd.start = start_q;
	assign dp_cmd.load_in = accept;
	assign dp_cmd.op = op_q;
	assign dp_cmd.a = a_q;
	assign dp_cmd.b = b_q;
	assign dp_cmd.d = d_q;
	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_inf = out_inf_q;

	`ECPA_NEVER(a_start_busy, start_q && dp_stat.busy)
	`ECPA_ASSERT(a_done_waits, dp_stat.done |-> st_q == S_WAIT)
	`ECPA_ASSERT(a_accept_leaves_idle, accept |=> st_q != S_IDLE)

endmodule

/* rtl/ec_point_add_scalar_multiply.sv */
// Affine elliptic curve point addition and scalar multiply over a prime field.
// One item at a time; the result goes straight to the output register, with no microcode,
// when the modulus is below 2 or a multiply has multiple 0. Otherwise each addition runs
// microcode on one shared restoring divider (for products mod p and Euclid divisions),
// with an inverse of up to about 23 rounds of the Euclid loop.
// A multiply repeats the addition multiple-1 times.
// Reset clears control state and sets modulus 13 and a 1; no clearing pass.
module ec_point_add_scalar_multiply (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// first_x, first_y, second_x, second_y, multiple
	input  logic [ecpa_pkg::SDataW-1:0]   s_tdata,
	// cmd
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// result_x, result_y
	output logic [ecpa_pkg::MDataW-1:0]   m_tdata,
	// at_infinity
	output logic                          m_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  ecpa_pkg::word_t               cfg_data
);

	localparam int W = ecpa_pkg::W;

	ecpa_pkg::word_t    modulus_q, curve_a_q, rd_a, rd_b, out_x, out_y;
	ecpa_pkg::dp_cmd_t  dp_cmd;
	ecpa_pkg::dp_stat_t dp_stat;
	logic               out_inf;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= W'(13);
			curve_a_q <= W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ecpa_pkg::CFG_MODULUS: modulus_q <= cfg_data;
				ecpa_pkg::CFG_CURVE_A: curve_a_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ecpa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_cmd      (s_tuser),
		.in_multiple (s_tdata[4*W +: ecpa_pkg::NW]),
		.m_small     (modulus_q < W'(2)),
		.dp_cmd      (dp_cmd),
		.dp_stat     (dp_stat),
		.rd_a        (rd_a),
		.rd_b        (rd_b),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_inf     (out_inf)
	);

	ecpa_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (dp_cmd),
		.stat     (dp_stat),
		.modulus  (modulus_q),
		.curve_a  (curve_a_q),
		.first_x  (s_tdata[0 +: W]),
		.first_y  (s_tdata[W +: W]),
		.second_x (s_tdata[2*W +: W]),
		.second_y (s_tdata[3*W +: W]),
		.rd_a     (rd_a),
		.rd_b     (rd_b)
	);

	assign m_tdata = ecpa_pkg::MDataW'({out_y, out_x});
	assign m_tuser = out_inf;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for ec_point_add_scalar_multiply: point additions and scalar multiplies
// are streamed in under several moduli and curve coefficients, and every result is compared
// against a behavioural model held here or a directed row's answer. Depends on ecpa_pkg and the block's RTL.
module testbench;

	localparam logic CMD_MUL = !ecpa_pkg::CMD_ADD;
	localparam int W = ecpa_pkg::W;
	localparam int NW = ecpa_pkg::NW;
	localparam int QUIET_TAIL = 60;
	localparam int HOLD_CYCLES = 30000;

	typedef struct {
		longint unsigned x;
		longint unsigned y;
		bit inf;
	} point_t;

	typedef struct packed {
		ecpa_pkg::word_t x;
		ecpa_pkg::word_t y;
		logic inf;
	} answer_t;

	typedef struct {
		logic cmd;
		ecpa_pkg::word_t fx, fy, sx, sy;
		ecpa_pkg::mult_t n;
		bit typed;
		answer_t ans;
	} row_t;

	typedef struct {
		int m;
		int a;
		int items;
	} setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [ecpa_pkg::SDataW-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b1;
	logic [ecpa_pkg::MDataW-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	ecpa_pkg::word_t cfg_data = '0;

	ec_point_add_scalar_multiply u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Field settings mirrored from the configuration transfers.
	longint unsigned field_p = 13;
	longint unsigned field_a = 1;

	answer_t pending_results[$];
	bit in_taken, cfg_taken;
	bit cur_typed;
	answer_t cur_answer;
	bit quiet, hold_req;
	int mismatches, n_add, n_mul, n_inf;

	function automatic longint unsigned sub_mod(longint unsigned u, longint unsigned v,
		longint unsigned m);
		return (u >= v) ? (u - v) : (u + m - v);
	endfunction

	// Extended Euclid; a denominator with no inverse yields zero.
	function automatic longint unsigned inverse_mod(longint unsigned v, longint unsigned m);
		longint unsigned r1, r2, q, r;
		longint t1, t2, t;
		r1 = m;
		r2 = v % m;
		t1 = 0;
		t2 = 1;
		while (r2 > 0) begin
			q = r1 / r2;
			r = r1 - q * r2;
			t = t1 - longint'(q) * t2;
			r1 = r2;
			r2 = r;
			t1 = t2;
			t2 = t;
		end
		if (r1 != 1)
			return 0;
		if (t1 < 0)
			t1 = t1 + longint'(m);
		return longint'(t1) % m;
	endfunction

	function automatic point_t point_sum(point_t p, point_t q, longint unsigned m,
		longint unsigned a);
		point_t r;
		longint unsigned lam, num, den;
		r = '{0, 0, 1'b1};
		if (p.inf)
			return q;
		if (q.inf)
			return p;
		if (p.x != q.x) begin
			num = sub_mod(q.y, p.y, m);
			den = sub_mod(q.x, p.x, m);
		end else begin
			den = (2 * p.y) % m;
			if (p.y != q.y || den == 0)
				return r;
			num = ((3 * ((p.x * p.x) % m)) % m + a) % m;
		end
		lam = (num * inverse_mod(den, m)) % m;
		r.x = sub_mod(sub_mod((lam * lam) % m, p.x, m), q.x, m);
		r.y = sub_mod((lam * sub_mod(p.x, r.x, m)) % m, p.y, m);
		r.inf = 1'b0;
		return r;
	endfunction

	function automatic answer_t curve_result(logic cmd, logic [ecpa_pkg::SDataW-1:0] d);
		point_t p, q, r;
		longint unsigned m, a;
		int n;
		answer_t ans;
		m = field_p;
		r = '{0, 0, 1'b1};
		if (m >= 2) begin
			a = field_a % m;
			p = '{longint'(d[W-1:0]) % m, longint'(d[2*W-1:W]) % m, 1'b0};
			q = '{longint'(d[3*W-1:2*W]) % m, longint'(d[4*W-1:3*W]) % m, 1'b0};
			if (cmd == ecpa_pkg::CMD_ADD) begin
				r = point_sum(p, q, m, a);
			end else begin
				n = int'(d[4*W+NW-1:4*W]);
				if (n > ecpa_pkg::MaxMultiple)
					n = ecpa_pkg::MaxMultiple;
				if (n > 0) begin
					r = p;
					for (int i = 1; i < n; i++)
						r = point_sum(r, p, m, a);
				end
			end
		end
		if (r.inf)
			ans = '{'0, '0, 1'b1};
		else
			ans = '{ecpa_pkg::word_t'(r.x), ecpa_pkg::word_t'(r.y), 1'b0};
		return ans;
	endfunction

	// Transfers are observed at the rising edge, before the block's registers move.
	always @(posedge clk) begin
		answer_t want, got;
		in_taken = s_tvalid && s_tready;
		cfg_taken = cfg_valid && cfg_ready;
		if (cfg_taken) begin
			if (cfg_index == ecpa_pkg::CFG_MODULUS)
				field_p = cfg_data;
			if (cfg_index == ecpa_pkg::CFG_CURVE_A)
				field_a = cfg_data;
		end
		if (in_taken) begin
			pending_results.push_back(cur_typed ? cur_answer : curve_result(s_tuser, s_tdata));
			if (s_tuser == ecpa_pkg::CMD_ADD)
				n_add++;
			else
				n_mul++;
		end
		if (m_tvalid && m_tready) begin
			got = '{m_tdata[W-1:0], m_tdata[2*W-1:W], m_tuser};
			if (got.inf)
				n_inf++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%0d y=%0d inf=%0b", got.x, got.y, got.inf);
			end else begin
				want = pending_results.pop_front();
				if (got.x != want.x || got.y != want.y || got.inf != want.inf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected x=%0d y=%0d inf=%0b, got x=%0d y=%0d inf=%0b",
							want.x, want.y, want.inf, got.x, got.y, got.inf);
				end
			end
		end
	end

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				m_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_point(row_t r);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		cur_typed = r.typed;
		cur_answer = r.ans;
		s_tvalid <= 1'b1;
		s_tuser <= r.cmd;
		s_tdata <= ecpa_pkg::SDataW'({r.n, r.sy, r.sx, r.fy, r.fx});
		do
			@(negedge clk);
		while (!in_taken);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
		// Let the block settle back to idle before anything is reconfigured.
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, ecpa_pkg::word_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic row_t random_row(int m, bit slow_field);
		row_t r;
		int pick;
		r.typed = 1'b0;
		r.ans = '0;
		r.cmd = 1'($urandom_range(0, 1));
		r.fx = ecpa_pkg::word_t'($urandom_range(0, m - 1));
		r.fy = ecpa_pkg::word_t'($urandom_range(0, m - 1));
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			r.sx = r.fx;
			r.sy = r.fy;
		end else if (pick < 35) begin
			r.sx = r.fx;
			r.sy = ecpa_pkg::word_t'($urandom_range(0, m - 1));
		end else if (pick < 45) begin
			r.sx = r.fx;
			r.sy = ecpa_pkg::word_t'((m - int'(r.fy)) % m);
		end else if (pick < 55) begin
			// Raw coordinates, often at or above the modulus.
			r.fx = ecpa_pkg::word_t'($urandom_range(0, 65534));
			r.fy = ecpa_pkg::word_t'($urandom_range(0, 65534));
			r.sx = ecpa_pkg::word_t'($urandom_range(0, 65534));
			r.sy = ecpa_pkg::word_t'($urandom_range(0, 65534));
		end else begin
			r.sx = ecpa_pkg::word_t'($urandom_range(0, m - 1));
			r.sy = ecpa_pkg::word_t'($urandom_range(0, m - 1));
		end
		if (slow_field)
			r.n = ecpa_pkg::mult_t'($urandom_range(1, 3));
		else if ($urandom_range(0, 49) == 0)
			r.n = ecpa_pkg::mult_t'($urandom_range(200, 255));
		else
			r.n = ecpa_pkg::mult_t'($urandom_range(1, 12));
		return r;
	endfunction

	row_t directed[] = '{
		'{ecpa_pkg::CMD_ADD, 16'd1, 16'd2, 16'd1, 16'd5, 8'd1, 1'b1, '{16'd0, 16'd0, 1'b1}},
		'{ecpa_pkg::CMD_ADD, 16'd1, 16'd2, 16'd1, 16'd11, 8'd1, 1'b1, '{16'd0, 16'd0, 1'b1}},
		'{ecpa_pkg::CMD_ADD, 16'd3, 16'd0, 16'd3, 16'd0, 8'd1, 1'b1, '{16'd0, 16'd0, 1'b1}},
		'{ecpa_pkg::CMD_ADD, 16'd0, 16'd0, 16'd0, 16'd0, 8'd1, 1'b1, '{16'd0, 16'd0, 1'b1}},
		'{ecpa_pkg::CMD_ADD, 16'd14, 16'd2, 16'd1, 16'd11, 8'd1, 1'b1, '{16'd0, 16'd0, 1'b1}},
		'{CMD_MUL, 16'd5, 16'd7, 16'd0, 16'd0, 8'd1, 1'b1, '{16'd5, 16'd7, 1'b0}},
		'{CMD_MUL, 16'd5, 16'd7, 16'd0, 16'd0, 8'd0, 1'b1, '{16'd0, 16'd0, 1'b1}},
		'{CMD_MUL, 16'd65534, 16'd65534, 16'd65534, 16'd65534, 8'd1, 1'b1,
			'{16'd1, 16'd1, 1'b0}},
		'{ecpa_pkg::CMD_ADD, 16'd1, 16'd2, 16'd3, 16'd4, 8'd0, 1'b0, '0},
		'{ecpa_pkg::CMD_ADD, 16'd2, 16'd3, 16'd2, 16'd3, 8'd0, 1'b0, '0},
		'{ecpa_pkg::CMD_ADD, 16'd65534, 16'd0, 16'd0, 16'd65534, 8'd255, 1'b0, '0},
		'{ecpa_pkg::CMD_ADD, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 8'hAA, 1'b0, '0},
		'{ecpa_pkg::CMD_ADD, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 8'h55, 1'b0, '0},
		'{CMD_MUL, 16'd0, 16'd1, 16'd0, 16'd0, 8'd2, 1'b0, '0},
		'{CMD_MUL, 16'd2, 16'd3, 16'd0, 16'd0, 8'd7, 1'b0, '0},
		'{CMD_MUL, 16'd2, 16'd3, 16'd0, 16'd0, 8'd128, 1'b0, '0},
		'{CMD_MUL, 16'd4, 16'd9, 16'd0, 16'd0, 8'd255, 1'b0, '0}
	};

	// Moduli: smallest, composites (no inverse for some slopes), primes and the largest word.
	setting_t phases[] = '{
		'{3, 0, 80}, '{65521, 65520, 40}, '{97, 200, 140}, '{15, 4, 110},
		'{65535, 65534, 25}, '{251, 3, 150}, '{7, 0, 90}, '{13, 1, 115}
	};

	int sent;

	initial begin
		row_t r;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed[i])
			send_point(directed[i]);
		drain_results();
		sent = 0;
		foreach (phases[p]) begin
			write_reg(ecpa_pkg::CFG_MODULUS, ecpa_pkg::word_t'(phases[p].m));
			write_reg(ecpa_pkg::CFG_CURVE_A, ecpa_pkg::word_t'(phases[p].a));
			for (int i = 0; i < phases[p].items; i++) begin
				if (p == 2 && i == 20)
					hold_req = 1'b1;
				if (p == 5 && i == 40) begin
					s_tvalid <= 1'b0;
					@(negedge clk);
					while (pending_results.size() != 0)
						@(negedge clk);
				end
				quiet = (p == phases.size() - 1) && (i >= phases[p].items - QUIET_TAIL);
				r = random_row(phases[p].m, phases[p].m > 4096);
				send_point(r);
				sent++;
			end
			drain_results();
		end
		$display("Covered %0d adds and %0d multiplies over %0d field settings,", n_add, n_mul,
			phases.size() + 1);
		$display("%0d of the results being the point at infinity.", n_inf);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#400_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
